/* src/sev_pkg.sv */
// sev_pkg: shared constants, types and the sine table of the sound effect voice
// depends on nothing; imported by every module of the block

package sev_pkg;

  // rates and formats
  localparam int SAMPLE_RATE = 44100;
  localparam int PHASE_BITS  = 24;
  localparam int STEP_W      = PHASE_BITS;
  localparam int FRAME_W     = 18;
  localparam int FRAME_CAP   = 262143;
  localparam int SINE_BITS   = 8;
  localparam int SINE_DEPTH  = 1 << SINE_BITS;
  localparam int SEED_STEPS  = 3;

  // divider geometry: quotient bits and dividend width
  localparam int DIV_Q_W   = 16;
  localparam int DIV_NUM_W = FRAME_W + 15;

  // step clamp limits, 1 Hz .. 20 kHz
  localparam longint STEP_HI_RAW = (64'd20000 << PHASE_BITS) / SAMPLE_RATE;
  localparam longint STEP_MASK   = (64'd1 << PHASE_BITS) - 1;
  localparam longint STEP_HI_L   = (STEP_HI_RAW > STEP_MASK) ? STEP_MASK : STEP_HI_RAW;
  localparam longint STEP_LO_L   = ((64'd1 << PHASE_BITS) + SAMPLE_RATE - 1) / SAMPLE_RATE;
  localparam logic [STEP_W-1:0] STEP_HI = STEP_W'(STEP_HI_L);
  localparam logic [STEP_W-1:0] STEP_LO = STEP_W'(STEP_LO_L);

  // noise hold dividend, an eighth of a full phase turn in phase units
  localparam logic [DIV_NUM_W-1:0] NOISE_NUM = DIV_NUM_W'(64'd1 << (PHASE_BITS - 3));

  // noise generator
  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_ADD = 32'd1013904223;

  // configuration register indexes
  localparam logic [2:0] CFG_WAVE    = 3'd0;
  localparam logic [2:0] CFG_ATTACK  = 3'd1;
  localparam logic [2:0] CFG_SUSTAIN = 3'd2;
  localparam logic [2:0] CFG_DECAY   = 3'd3;
  localparam logic [2:0] CFG_STEP    = 3'd4;
  localparam logic [2:0] CFG_SLIDE   = 3'd5;
  localparam logic [2:0] CFG_LOWPASS = 3'd6;
  localparam logic [2:0] CFG_HIPASS  = 3'd7;

  // wave shape codes
  localparam logic [2:0] WAVE_SQUARE = 3'd0;
  localparam logic [2:0] WAVE_SAW    = 3'd1;
  localparam logic [2:0] WAVE_TRI    = 3'd2;
  localparam logic [2:0] WAVE_SINE   = 3'd3;

  // shared multiplier operand select
  typedef enum logic [1:0] {
    MUL_ENV   = 2'd0,
    MUL_LP    = 2'd1,
    MUL_HP    = 2'd2,
    MUL_SLIDE = 2'd3
  } mul_sel_e;

  // controller to datapath commands
  typedef struct packed {
    logic     start_load;
    logic     lcg_step;
    logic     frame_begin;
    logic     give_idle;
    logic     div_start;
    logic     div_noise;
    logic     hold_load;
    logic     env_direct;
    logic     env_load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     scale;
    logic     lp_upd;
    logic     hp_upd;
    logic     fin;
    logic     out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic active;
    logic noise_draw;
    logic env_div;
    logic lp_en;
    logic hp_en;
    logic div_done;
    logic out_free;
  } sts_t;

  // sine table, quarter-wave 5th-order polynomial
  typedef logic signed [16:0] sine_tab_t [SINE_DEPTH];

  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    longint q, r, z, z2, t;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      q = (4 * k) >> SINE_BITS;
      r = (4 * k) & (SINE_DEPTH - 1);
      z = (r * 32768) >> SINE_BITS;
      if (q[0]) z = 32768 - z;
      z2 = (z * z) >> 15;
      t = (2320 * z2) >> 15;
      t = 21024 - t;
      t = (z2 * t) >> 15;
      t = 51472 - t;
      t = (z * t) >> 15;
      tab[k] = 17'(q[1] ? -t : t);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  // clamp a slid step into the audible range
  function automatic logic [STEP_W-1:0] clamp_step(input logic [STEP_W+1:0] s);
    logic [STEP_W-1:0] r;
    if (s > {2'b00, STEP_HI}) r = STEP_HI;
    else if (s < {2'b00, STEP_LO}) r = STEP_LO;
    else r = s[STEP_W-1:0];
    return r;
  endfunction

  // one noise generator step
  function automatic logic [31:0] lcg_next(input logic [31:0] s);
    return 32'(s * LCG_MUL) + LCG_ADD;
  endfunction

endpackage

/* src/sev_div.sv */
// sev_div: restoring divider, one quotient bit per cycle
// depends on sev_pkg; used by sev_dp for envelope and noise hold

module sev_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [sev_pkg::DIV_NUM_W-1:0]  num_i,
  input  logic [sev_pkg::STEP_W-1:0]     den_i,
  output logic                           done_o,
  output logic [sev_pkg::DIV_Q_W-1:0]    quo_o
);
  import sev_pkg::*;

  localparam int CNT_W = $clog2(DIV_Q_W);

  logic               busy_q, done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [STEP_W-1:0]  rem_q, den_q;
  logic [DIV_Q_W-1:0] low_q, quo_q;
  logic [STEP_W:0]    trial;
  logic               fits;

  // trial subtract of the next dividend bit
  assign trial = {rem_q, low_q[DIV_Q_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_Q_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= STEP_W'(num_i >> DIV_Q_W);
      low_q <= num_i[DIV_Q_W-1:0];
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? STEP_W'(trial - {1'b0, den_q}) : trial[STEP_W-1:0];
      low_q <= {low_q[DIV_Q_W-2:0], 1'b0};
      quo_q <= {quo_q[DIV_Q_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

/* src/sev_dp.sv */
// sev_dp: voice datapath: config registers, oscillator, envelope, filters, output register
// depends on sev_pkg and sev_div; driven by sev_ctrl commands

module sev_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  logic [31:0]         seed_i,
  input  sev_pkg::cmd_t       cmd_i,
  output sev_pkg::sts_t       sts_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic signed [15:0]  sample_o,
  output logic                last_o,
  output logic                idle_o
);
  import sev_pkg::*;

  // configuration
  logic [2:0]         wave_q;
  logic [FRAME_W-1:0] attack_q, sustain_q, decay_q;
  logic [STEP_W-1:0]  start_step_q;
  logic [31:0]        slide_q;
  logic [15:0]        lp_coef_q, hp_coef_q;

  // voice state
  logic [31:0]         rng_q;
  logic [STEP_W-1:0]   phase_q, step_q;
  logic [FRAME_W-1:0]  idx_q;
  logic signed [17:0]  lpm_q, hpm_q;
  logic signed [15:0]  noise_q;
  logic [15:0]         hold_q;
  logic                playing_q;

  // frame work registers
  logic signed [16:0]  x_q;
  logic [15:0]         env_q;
  logic signed [18:0]  xs_q;
  logic signed [57:0]  prod_q;
  logic signed [15:0]  res_sample_q;
  logic                res_last_q, res_idle_q;
  logic                out_valid_q;
  logic signed [15:0]  sample_q;
  logic                last_q, idle_q;

  // frame length and envelope region
  logic [FRAME_W+1:0]  len_sum;
  logic [FRAME_W-1:0]  total;
  logic [FRAME_W:0]    att_sus, idx_inc;
  logic [FRAME_W:0]    j_wide;
  logic [FRAME_W-1:0]  j;
  logic                in_attack, in_sustain, decay_div;

  assign len_sum = {2'b00, attack_q} + {2'b00, sustain_q} + {2'b00, decay_q};
  assign total   = (len_sum > (FRAME_W+2)'(FRAME_CAP)) ? FRAME_W'(FRAME_CAP)
                                                      : len_sum[FRAME_W-1:0];
  assign att_sus    = {1'b0, attack_q} + {1'b0, sustain_q};
  assign idx_inc    = {1'b0, idx_q} + 1'b1;
  assign j_wide     = {1'b0, idx_q} - att_sus;
  assign j          = j_wide[FRAME_W-1:0];
  assign in_attack  = idx_q < attack_q;
  assign in_sustain = !in_attack && ({1'b0, idx_q} < att_sus);
  assign decay_div  = !in_attack && !in_sustain && (decay_q != '0) && (j < decay_q);

  // oscillator on the advanced phase
  logic [STEP_W-1:0]   phase_nx;
  logic [15:0]         p16;
  logic signed [17:0]  p2, tri18;
  logic [31:0]         rng_nx;
  logic signed [15:0]  noise_nx;
  logic                is_noise, draw;
  logic signed [16:0]  x_wave;

  assign phase_nx = phase_q + step_q;
  assign p16      = phase_nx[STEP_W-1 -: 16];
  assign p2       = $signed({1'b0, p16, 1'b0});
  assign tri18    = p16[15] ? (18'sd98304 - p2) : (p2 - 18'sd32768);
  assign rng_nx   = lcg_next(rng_q);
  assign noise_nx = $signed({~rng_nx[23], rng_nx[22:8]});
  assign is_noise = wave_q[2];
  assign draw     = is_noise && (hold_q == '0);

  always_comb begin
    case (wave_q)
      WAVE_SQUARE: x_wave = p16[15] ? -17'sd32768 : 17'sd32768;
      WAVE_SAW:    x_wave = $signed({{2{~p16[15]}}, p16[14:0]});
      WAVE_TRI:    x_wave = tri18[16:0];
      WAVE_SINE:   x_wave = SINE_TAB[phase_nx[STEP_W-1 -: SINE_BITS]];
      default:     x_wave = draw ? 17'(noise_nx) : 17'(noise_q);
    endcase
  end

  // shared divider
  logic [DIV_NUM_W-1:0] div_num;
  logic [STEP_W-1:0]    div_den;
  logic                 div_done;
  logic [DIV_Q_W-1:0]   quo;

  assign div_num = cmd_i.div_noise ? NOISE_NUM
                                   : {(in_attack ? idx_q : j), 15'd0};
  assign div_den = cmd_i.div_noise ? step_q
                                   : {{(STEP_W-FRAME_W){1'b0}}, (in_attack ? attack_q : decay_q)};

  sev_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // shared multiplier operands
  logic [15:0]         lp_a, hp_a;
  logic signed [19:0]  lp_diff, hp_diff;
  logic signed [24:0]  mul_a;
  logic signed [32:0]  mul_b;

  assign lp_a    = (lp_coef_q > 16'd32768) ? 16'd32768 : lp_coef_q;
  assign hp_a    = (hp_coef_q > 16'd32768) ? 16'd32768 : hp_coef_q;
  assign lp_diff = 20'(xs_q) - 20'(lpm_q);
  assign hp_diff = 20'(xs_q) - 20'(hpm_q);

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_ENV: begin
        mul_a = $signed({9'd0, env_q});
        mul_b = 33'(x_q);
      end
      MUL_LP: begin
        mul_a = $signed({9'd0, lp_a});
        mul_b = 33'(lp_diff);
      end
      MUL_HP: begin
        mul_a = $signed({9'd0, hp_a});
        mul_b = 33'(hp_diff);
      end
      MUL_SLIDE: begin
        mul_a = $signed({1'b0, step_q});
        mul_b = $signed({1'b0, slide_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // product scaling and filter memory update
  logic signed [57:0] scaled;
  logic signed [21:0] lp_sum, hp_sum;
  logic signed [17:0] lpm_d, hpm_d;
  logic signed [15:0] sat_out;

  assign scaled = prod_q >>> 15;
  assign lp_sum = 22'(lpm_q) + 22'($signed(scaled[20:0]));
  assign hp_sum = 22'(hpm_q) + 22'($signed(scaled[20:0]));

  always_comb begin
    if (lp_sum > 22'sd131071) lpm_d = 18'sd131071;
    else if (lp_sum < -22'sd131072) lpm_d = -18'sd131072;
    else lpm_d = lp_sum[17:0];
    if (hp_sum > 22'sd131071) hpm_d = 18'sd131071;
    else if (hp_sum < -22'sd131072) hpm_d = -18'sd131072;
    else hpm_d = hp_sum[17:0];
    if (xs_q > 19'sd32767) sat_out = 16'sh7fff;
    else if (xs_q < -19'sd32768) sat_out = -16'sh8000;
    else sat_out = xs_q[15:0];
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q       <= '0;
      attack_q     <= '0;
      sustain_q    <= '0;
      decay_q      <= '0;
      start_step_q <= '0;
      slide_q      <= 32'h4000_0000;
      lp_coef_q    <= '0;
      hp_coef_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WAVE:    wave_q       <= cfg_data_i[2:0];
        CFG_ATTACK:  attack_q     <= cfg_data_i[FRAME_W-1:0];
        CFG_SUSTAIN: sustain_q    <= cfg_data_i[FRAME_W-1:0];
        CFG_DECAY:   decay_q      <= cfg_data_i[FRAME_W-1:0];
        CFG_STEP:    start_step_q <= cfg_data_i[STEP_W-1:0];
        CFG_SLIDE:   slide_q      <= cfg_data_i;
        CFG_LOWPASS: lp_coef_q    <= cfg_data_i[15:0];
        CFG_HIPASS:  hp_coef_q    <= cfg_data_i[15:0];
        default:     ;
      endcase
    end
  end

  // voice state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rng_q     <= 32'd1;
      phase_q   <= '0;
      step_q    <= '0;
      idx_q     <= '0;
      lpm_q     <= '0;
      hpm_q     <= '0;
      noise_q   <= '0;
      hold_q    <= '0;
      playing_q <= 1'b0;
    end else begin
      if (cmd_i.start_load) begin
        rng_q     <= (seed_i == '0) ? 32'd1 : seed_i;
        phase_q   <= '0;
        step_q    <= clamp_step({2'b00, start_step_q});
        idx_q     <= '0;
        lpm_q     <= '0;
        hpm_q     <= '0;
        noise_q   <= '0;
        hold_q    <= '0;
        playing_q <= total != '0;
      end
      if (cmd_i.lcg_step) rng_q <= rng_nx;
      if (cmd_i.give_idle) playing_q <= 1'b0;
      if (cmd_i.frame_begin) begin
        phase_q <= phase_nx;
        if (draw) begin
          rng_q   <= rng_nx;
          noise_q <= noise_nx;
        end else if (is_noise) begin
          hold_q <= hold_q - 1'b1;
        end
      end
      // hold is reloaded and already counted down for this frame
      if (cmd_i.hold_load) hold_q <= (quo == '0) ? 16'd0 : quo - 1'b1;
      if (cmd_i.lp_upd) lpm_q <= lpm_d;
      if (cmd_i.hp_upd) hpm_q <= hpm_d;
      if (cmd_i.fin) begin
        step_q    <= clamp_step(prod_q[55:30]);
        idx_q     <= idx_inc[FRAME_W-1:0];
        playing_q <= idx_inc < {1'b0, total};
      end
    end
  end

  // frame work registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.frame_begin) x_q <= x_wave;
    if (cmd_i.env_direct) env_q <= in_sustain ? 16'd32768 : 16'd0;
    if (cmd_i.env_load) env_q <= in_attack ? quo : 16'd32768 - quo;
    if (cmd_i.mul_en) prod_q <= mul_a * mul_b;
    if (cmd_i.scale) xs_q <= scaled[18:0];
    if (cmd_i.lp_upd) xs_q <= 19'(lpm_d);
    if (cmd_i.hp_upd) xs_q <= xs_q - 19'(hpm_d);
    if (cmd_i.give_idle) begin
      res_sample_q <= '0;
      res_last_q   <= 1'b0;
      res_idle_q   <= 1'b1;
    end
    if (cmd_i.fin) begin
      res_sample_q <= sat_out;
      res_last_q   <= idx_inc == {1'b0, total};
      res_idle_q   <= 1'b0;
    end
    if (cmd_i.out_load) begin
      sample_q <= res_sample_q;
      last_q   <= res_last_q;
      idle_q   <= res_idle_q;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // status to the controller
  assign sts_o.active     = playing_q && (idx_q < total);
  assign sts_o.noise_draw = draw;
  assign sts_o.env_div    = in_attack || decay_div;
  assign sts_o.lp_en      = lp_coef_q != '0;
  assign sts_o.hp_en      = hp_coef_q != '0;
  assign sts_o.div_done   = div_done;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign last_o      = last_q;
  assign idle_o      = idle_q;

endmodule

/* src/sev_ctrl.sv */
// sev_ctrl: frame sequencer of the sound effect voice
// depends on sev_pkg; issues commands to sev_dp and reads its status

module sev_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           req_type_i,
  input  sev_pkg::sts_t  sts_i,
  output sev_pkg::cmd_t  cmd_o,
  output logic           in_stall_o
);
  import sev_pkg::*;

  typedef enum logic [14:0] {
    ST_IDLE  = 15'h0001,
    ST_SEED  = 15'h0002,
    ST_CHECK = 15'h0004,
    ST_NDIV  = 15'h0008,
    ST_ENV   = 15'h0010,
    ST_EDIV  = 15'h0020,
    ST_MENV  = 15'h0040,
    ST_SCL   = 15'h0080,
    ST_MLP   = 15'h0100,
    ST_ULP   = 15'h0200,
    ST_MHP   = 15'h0400,
    ST_UHP   = 15'h0800,
    ST_MSL   = 15'h1000,
    ST_FIN   = 15'h2000,
    ST_OUT   = 15'h4000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cmd;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd     = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.start_load = req_type_i;
          cnt_d          = '0;
          state_d        = req_type_i ? ST_SEED : ST_CHECK;
        end
      end
      ST_SEED: begin
        cmd.lcg_step = 1'b1;
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == 2'(SEED_STEPS - 1)) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.active) begin
          cmd.frame_begin = 1'b1;
          if (sts_i.noise_draw) begin
            cmd.div_start = 1'b1;
            cmd.div_noise = 1'b1;
            state_d       = ST_NDIV;
          end else begin
            state_d = ST_ENV;
          end
        end else begin
          cmd.give_idle = 1'b1;
          state_d       = ST_OUT;
        end
      end
      ST_NDIV: begin
        if (sts_i.div_done) begin
          cmd.hold_load = 1'b1;
          state_d       = ST_ENV;
        end
      end
      ST_ENV: begin
        if (sts_i.env_div) begin
          cmd.div_start = 1'b1;
          state_d       = ST_EDIV;
        end else begin
          cmd.env_direct = 1'b1;
          state_d        = ST_MENV;
        end
      end
      ST_EDIV: begin
        if (sts_i.div_done) begin
          cmd.env_load = 1'b1;
          state_d      = ST_MENV;
        end
      end
      ST_MENV: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ENV;
        state_d     = ST_SCL;
      end
      ST_SCL: begin
        cmd.scale = 1'b1;
        if (sts_i.lp_en) state_d = ST_MLP;
        else if (sts_i.hp_en) state_d = ST_MHP;
        else state_d = ST_MSL;
      end
      ST_MLP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LP;
        state_d     = ST_ULP;
      end
      ST_ULP: begin
        cmd.lp_upd = 1'b1;
        state_d    = sts_i.hp_en ? ST_MHP : ST_MSL;
      end
      ST_MHP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_HP;
        state_d     = ST_UHP;
      end
      ST_UHP: begin
        cmd.hp_upd = 1'b1;
        state_d    = ST_MSL;
      end
      ST_MSL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SLIDE;
        state_d     = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd.out_load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign cmd_o      = cmd;
  assign in_stall_o = state_q != ST_IDLE;

endmodule

/* src/sound_effect_voice.sv */
// sound_effect_voice: top level, joins the frame sequencer and the voice datapath
// depends on sev_pkg, sev_ctrl, sev_dp (and sev_div inside sev_dp)

// One-voice sound-effect generator. Each request gives one signed Q1.15 sample:
// a start request reseeds the noise generator and restarts the voice, an advance
// request gives the next frame. One request is worked on at a time; the block
// takes a new request while the previous sample still waits in the output
// register. A frame takes longer for each enabled filter, for the 16-step shared
// divider when the envelope ramps and again when noise draws a new value, for the
// seed steps on a start, and while the output register stays stalled. The divider
// and the single shared multiplier set the length of a frame.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i only while idle;
// the user must keep to that, the block itself does not enforce it.

module sound_effect_voice (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [31:0]        seed_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] sample_o,
  output logic               last_o,
  output logic               idle_o
);
  import sev_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sev_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  sev_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .seed_i      (seed_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .sample_o    (sample_o),
    .last_o      (last_o),
    .idle_o      (idle_o)
  );

`ifndef NO_ASSERTIONS
  // an accepted request keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted but block not busy");

  // an idle result carries a zero sample and no last flag
  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && idle_o |-> (sample_o == 16'sd0) && !last_o)
    else $error("idle result with sound");

  // a new result is loaded only when the output register is free
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !out_valid_o || !out_stall_i)
    else $error("result overwritten while stalled");
`endif

endmodule

/* tb/sv/sound_effect_voice_test.sv */
// sound_effect_voice_test: self-checking testbench of the sound effect voice
// depends on sev_pkg and sound_effect_voice; predicts every sample in-line
`timescale 1ns / 100ps

module sound_effect_voice_test;
  import sev_pkg::*;

  localparam int REQ_ADVANCE = 0;
  localparam int REQ_START   = 1;
  localparam logic [2:0] WAVE_NOISE = 3'd4;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic        kind;
    logic [31:0] seed;
  } voice_req_t;

  typedef struct {
    logic signed [15:0] sample;
    logic               last;
    logic               idle;
  } voice_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic req_type_i = 1'b0;
  logic [31:0] seed_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] sample_o;
  logic last_o, idle_o;

  sound_effect_voice DUT (.*);

  always #5 clk_i = ~clk_i;

  // predictor registers and state
  logic [2:0]  p_wave;
  logic [17:0] p_att, p_sus, p_dec;
  logic [23:0] p_step0;
  logic [31:0] p_slide;
  logic [15:0] p_lp, p_hp;
  logic [31:0] p_rng;
  logic [23:0] p_acc, p_step;
  longint      p_frame, p_hold, p_lpm, p_hpm, p_noise;
  bit          p_play;

  voice_req_t pending_reqs[$];
  voice_out_t expected_samples[$];
  bit failed = 0;
  longint cycles = 0;
  int rx_count = 0;

  function automatic longint fq15(longint v);
    return (v >= 0) ? (v >>> 15) : -(((-v) + 32767) >>> 15);
  endfunction

  function automatic longint sat(longint v, int bits);
    longint hi = (64'sd1 <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic logic [23:0] limit_step(longint s);
    if (s > STEP_HI_L) return STEP_HI_L[23:0];
    if (s < STEP_LO_L) return STEP_LO_L[23:0];
    return s[23:0];
  endfunction

  function automatic longint sine_val(longint k);
    longint q, r, z, z2, t;
    q = (4 * k) / 256;
    r = 4 * k - q * 256;
    z = (r * 32768) / 256;
    if (q[0]) z = 32768 - z;
    z2 = (z * z) >>> 15;
    t = 21024 - ((2320 * z2) >>> 15);
    t = 51472 - ((z2 * t) >>> 15);
    t = (z * t) >>> 15;
    return q[1] ? -t : t;
  endfunction

  function automatic void lcg_step();
    p_rng = p_rng * 32'd1664525 + 32'd1013904223;
  endfunction

  function automatic void voice_reset();
    p_wave = 0; p_att = 0; p_sus = 0; p_dec = 0; p_step0 = 0;
    p_slide = 32'h4000_0000; p_lp = 0; p_hp = 0;
    p_rng = 1; p_acc = 0; p_step = 0; p_frame = 0; p_lpm = 0; p_hpm = 0;
    p_noise = 0; p_hold = 0; p_play = 0;
  endfunction

  function automatic void voice_write(logic [2:0] idx, logic [31:0] d);
    case (idx)
      CFG_WAVE:    p_wave = d[2:0];
      CFG_ATTACK:  p_att = d[17:0];
      CFG_SUSTAIN: p_sus = d[17:0];
      CFG_DECAY:   p_dec = d[17:0];
      CFG_STEP:    p_step0 = d[23:0];
      CFG_SLIDE:   p_slide = d;
      CFG_LOWPASS: p_lp = d[15:0];
      default:     p_hp = d[15:0];
    endcase
  endfunction

  // one request through the voice model
  function automatic voice_out_t voice_predict(voice_req_t r);
    voice_out_t o;
    longint total, i, env, j, p16, x, a, h;
    total = longint'(p_att) + p_sus + p_dec;
    if (total > FRAME_CAP) total = FRAME_CAP;
    if (r.kind) begin
      p_rng = (r.seed != 0) ? r.seed : 32'd1;
      repeat (SEED_STEPS) lcg_step();
      p_acc = 0; p_step = limit_step(p_step0); p_frame = 0;
      p_lpm = 0; p_hpm = 0; p_noise = 0; p_hold = 0; p_play = total > 0;
    end
    if (p_play && p_frame >= total) p_play = 0;
    o.sample = 0; o.last = 0; o.idle = 1;
    if (!p_play) return o;
    i = p_frame;
    if (i < p_att) env = (i * 32768) / p_att;
    else if (i < longint'(p_att) + p_sus) env = 32768;
    else if (p_dec != 0) begin
      j = i - p_att - p_sus;
      env = (j >= p_dec) ? 0 : 32768 - (j * 32768) / p_dec;
    end else env = 0;
    p_acc = p_acc + p_step;
    p16 = p_acc[23:8];
    case (p_wave)
      WAVE_SQUARE: x = (p16 < 32768) ? 32768 : -32768;
      WAVE_SAW:    x = p16 - 32768;
      WAVE_TRI:    x = (p16 < 32768) ? 2 * p16 - 32768 : 98304 - 2 * p16;
      WAVE_SINE:   x = sine_val(p_acc[23:16]);
      default: begin
        if (p_hold == 0) begin
          lcg_step();
          p_noise = longint'(p_rng[23:8]) - 32768;
          h = (64'd1 << 21) / p_step;
          if (h < 1) h = 1;
          if (h > 16'hFFFF) h = 16'hFFFF;
          p_hold = h;
        end
        p_hold--;
        x = p_noise;
      end
    endcase
    x = fq15(x * env);
    if (p_lp != 0) begin
      a = (p_lp > 32768) ? 32768 : p_lp;
      p_lpm = sat(p_lpm + fq15(a * (x - p_lpm)), 18);
      x = p_lpm;
    end
    if (p_hp != 0) begin
      a = (p_hp > 32768) ? 32768 : p_hp;
      p_hpm = sat(p_hpm + fq15(a * (x - p_hpm)), 18);
      x = x - p_hpm;
    end
    o.sample = 16'(sat(x, 16));
    o.last = (i + 1 == total);
    o.idle = 0;
    p_step = limit_step((longint'(p_step) * p_slide) >>> 30);
    p_frame++;
    if (p_frame >= total) p_play = 0;
    return o;
  endfunction

  // request driver: bursts and gaps
  int gap_left = 0, burst_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni && !(in_valid_i && in_stall_o)) begin
      if (in_valid_i) expected_samples.push_back(voice_predict('{req_type_i, seed_i}));
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        voice_req_t r;
        r = pending_reqs.pop_front();
        in_valid_i <= 1'b1;
        req_type_i <= r.kind;
        seed_i <= r.seed;
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(0, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else in_valid_i <= 1'b0;
    end
  end

  // sample monitor and receiver stall pattern
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        rx_count <= rx_count + 1;
        if (expected_samples.size() == 0) begin
          $display("%0t: sample with none expected: got %0d/%0b/%0b", $time,
                   sample_o, last_o, idle_o);
          failed = 1;
        end else begin
          voice_out_t e;
          e = expected_samples.pop_front();
          if (e.sample !== sample_o || e.last !== last_o || e.idle !== idle_o) begin
            $display("%0t: mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b", $time,
                     e.sample, e.last, e.idle, sample_o, last_o, idle_o);
            failed = 1;
          end
        end
      end
      out_stall_i <= ((cycles / 500) % 3 == 0) ? 1'b0 : ($urandom_range(0, 9) < 4);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= d;
    voice_write(idx, d);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push(logic kind, logic [31:0] seed);
    pending_reqs.push_back('{kind, seed});
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid_i || expected_samples.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // random voice setup
  task automatic setup_voice(bit wide);
    write_reg(CFG_WAVE, $urandom_range(0, 7));
    write_reg(CFG_ATTACK, wide ? $urandom : $urandom_range(0, 12));
    write_reg(CFG_SUSTAIN, wide ? $urandom : $urandom_range(0, 12));
    write_reg(CFG_DECAY, wide ? $urandom : $urandom_range(0, 12));
    write_reg(CFG_STEP, $urandom);
    write_reg(CFG_SLIDE, ($urandom_range(0, 2) == 0) ? $urandom
                         : 32'h4000_0000 + $urandom_range(0, 32'h0400_0000) - 32'h0200_0000);
    write_reg(CFG_LOWPASS, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16'hFFFF));
    write_reg(CFG_HIPASS, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 40000));
  endtask

  initial begin
    voice_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: idle advance, zero length start, each shape with extremes
    push(REQ_ADVANCE, 0);
    push(REQ_START, 0);
    drain();
    write_reg(CFG_ATTACK, 3); write_reg(CFG_SUSTAIN, 2); write_reg(CFG_DECAY, 3);
    write_reg(CFG_STEP, 24'hFFFFFF); write_reg(CFG_SLIDE, 32'hFFFF_FFFF);
    write_reg(CFG_LOWPASS, 16'hFFFF); write_reg(CFG_HIPASS, 16'd32768);
    for (int w = 0; w < 8; w++) begin
      write_reg(CFG_WAVE, w);
      push(REQ_START, (w == 4) ? 32'hFFFF_FFFF : 0);
      repeat (3) push(REQ_ADVANCE, $urandom);
      drain();
      if (w == 4) begin
        write_reg(CFG_STEP, 0); write_reg(CFG_SLIDE, 0);
        write_reg(CFG_LOWPASS, 1); write_reg(CFG_HIPASS, 0);
      end
    end
    drain();
    // shrunk lengths while playing
    write_reg(CFG_SUSTAIN, 0); write_reg(CFG_DECAY, 0); write_reg(CFG_ATTACK, 0);
    push(REQ_ADVANCE, 0);
    drain();
    // large lengths, a few frames only
    write_reg(CFG_ATTACK, 18'h3FFFF); write_reg(CFG_SUSTAIN, 18'h3FFFF);
    write_reg(CFG_DECAY, 18'h3FFFF);
    push(REQ_START, 32'h8000_0001); push(REQ_ADVANCE, 0);
    drain();
    // random phases
    for (int ph = 0; ph < 30; ph++) begin
      setup_voice(ph % 6 == 5);
      push(REQ_START, $urandom);
      for (int n = 0; n < 13; n++)
        push(($urandom_range(0, 15) == 0) ? REQ_START : REQ_ADVANCE, $urandom);
      drain();
    end
    if (!failed) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // watchdog
  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
